// ===== hw/rtl/srbn_pkg.sv =====
// Shared types, request codes and state encoding for the line buffer navigator.
package srbn_pkg;

  localparam int STORE_BYTES_DEF = 16384;
  localparam int FIELD_W         = 14;

  typedef enum logic [3:0] {
    REQ_APPEND    = 4'd0,
    REQ_NEXT      = 4'd1,
    REQ_PREV      = 4'd2,
    REQ_GOTO      = 4'd3,
    REQ_TRY       = 4'd4,
    REQ_BEGIN     = 4'd5,
    REQ_END       = 4'd6,
    REQ_GOTO_POS  = 4'd7,
    REQ_SET_WRITE = 4'd8,
    REQ_SET_BEGIN = 4'd9,
    REQ_READ      = 4'd10,
    REQ_WRITE     = 4'd11,
    REQ_CLEAR     = 4'd12
  } req_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_NSCAN,
    ST_PCHK,
    ST_PSCAN,
    ST_END,
    ST_READ,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [7:0]         data_byte;
    logic [FIELD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic               status;
    logic [FIELD_W-1:0] read_pos;
    logic [FIELD_W-1:0] line_number;
    logic [FIELD_W-1:0] write_pos;
    logic [FIELD_W-1:0] begin_pos;
    logic [7:0]         read_data;
    logic [FIELD_W-1:0] remaining;
  } out_t;

endpackage

// ===== hw/rtl/srbn_mem.sv =====
// Byte-wide text store: one write port, one registered read port.
module srbn_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/srbn_ctrl.sv =====
// Request sequencer: pointers, line counter and the byte scans over the text store.
module srbn_ctrl #(
  parameter int STORE_BYTES = 16384,
  parameter int AW          = 14
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  srbn_pkg::in_t  req,
  output logic           res_valid,
  input  logic           res_ready,
  output srbn_pkg::out_t res,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output logic [7:0]     mem_wdata,
  output logic [AW-1:0]  mem_raddr,
  input  logic [7:0]     mem_rdata
);
  import srbn_pkg::*;

  localparam int CW = (AW > FIELD_W) ? AW : FIELD_W;
  localparam logic [CW:0]   SB_X = (CW+1)'(STORE_BYTES);
  localparam logic [AW+1:0] SB_A = (AW+2)'(STORE_BYTES);
  localparam logic [AW:0]   SB_P = (AW+1)'(STORE_BYTES);

  state_t state, state_next;
  logic [AW-1:0] wp, wp_next, rp, rp_next, rs, rs_next;
  logic [FIELD_W-1:0] lc, lc_next, target, target_next;
  logic [AW:0] pl, pl_next;
  logic fwd, fwd_next, multi, multi_next, is_try, is_try_next;
  logic [AW-1:0] save_rp, save_rp_next;
  logic [FIELD_W-1:0] save_lc, save_lc_next;
  logic [AW-1:0] scan_addr, scan_addr_next, chk_addr, chk_addr_next;
  logic scan_on, scan_on_next, chk_v, chk_v_next;
  logic ok, ok_next;
  logic [7:0] rdata, rdata_next;

  logic step_ok, step_fail;
  logic [CW:0] val_x, wp_x, rp_x, rs_x;
  logic [AW+1:0] app_addr;
  logic [AW-1:0] shown_rp;

  assign val_x    = (CW+1)'(req.value);
  assign wp_x     = (CW+1)'(wp);
  assign rp_x     = (CW+1)'(rp);
  assign rs_x     = (CW+1)'(rs);
  assign app_addr = (AW+2)'(wp) + (AW+2)'(pl);

  always_comb begin
    state_next     = state;
    wp_next        = wp;
    rp_next        = rp;
    rs_next        = rs;
    lc_next        = lc;
    pl_next        = pl;
    target_next    = target;
    fwd_next       = fwd;
    multi_next     = multi;
    is_try_next    = is_try;
    save_rp_next   = save_rp;
    save_lc_next   = save_lc;
    scan_addr_next = scan_addr;
    scan_on_next   = scan_on;
    chk_addr_next  = chk_addr;
    chk_v_next     = chk_v;
    ok_next        = ok;
    rdata_next     = rdata;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = '0;
    step_ok        = 1'b0;
    step_fail      = 1'b0;
    req_stall      = (state != ST_IDLE);
    res_valid      = (state == ST_FIN);

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ok_next     = 1'b1;
          rdata_next  = '0;
          is_try_next = 1'b0;
          multi_next  = 1'b0;
          state_next  = ST_FIN;
          unique case (req.req_type)
            REQ_APPEND: begin
              if (req.data_byte != 8'd0) begin
                if (app_addr < SB_A - 1'b1) begin
                  mem_we    = 1'b1;
                  mem_waddr = app_addr[AW-1:0];
                  mem_wdata = req.data_byte;
                end
                if (pl < SB_P) begin
                  pl_next = pl + 1'b1;
                end
              end else begin
                if (app_addr + 1'b1 < SB_A) begin
                  mem_we    = 1'b1;
                  mem_waddr = app_addr[AW-1:0];
                  mem_wdata = 8'd0;
                  wp_next   = AW'(app_addr + 1'b1);
                end else begin
                  ok_next = 1'b0;
                end
                pl_next = '0;
              end
            end
            REQ_NEXT: begin
              fwd_next   = 1'b1;
              state_next = ST_STEP;
            end
            REQ_PREV: begin
              fwd_next   = 1'b0;
              state_next = ST_STEP;
            end
            REQ_GOTO, REQ_TRY: begin
              target_next  = req.value;
              multi_next   = 1'b1;
              is_try_next  = (req.req_type == REQ_TRY);
              save_rp_next = rp;
              save_lc_next = lc;
              if (lc < req.value) begin
                fwd_next   = 1'b1;
                state_next = ST_STEP;
              end else if (lc > req.value) begin
                fwd_next   = 1'b0;
                state_next = ST_STEP;
              end
            end
            REQ_BEGIN: begin
              lc_next = '0;
              if (rs <= wp) begin
                rp_next = rs;
              end else begin
                ok_next = 1'b0;
              end
            end
            REQ_END: begin
              lc_next = '0;
              if (wp != '0) begin
                mem_raddr  = wp - 1'b1;
                state_next = ST_END;
              end else begin
                ok_next = 1'b0;
              end
            end
            REQ_GOTO_POS: begin
              if (val_x >= rs_x && val_x <= wp_x) begin
                rp_next = val_x[AW-1:0];
              end else begin
                ok_next = 1'b0;
              end
            end
            REQ_SET_WRITE: begin
              if (val_x < SB_X && val_x >= rs_x && val_x >= rp_x) begin
                wp_next = val_x[AW-1:0];
                pl_next = '0;
              end else begin
                ok_next = 1'b0;
              end
            end
            REQ_SET_BEGIN: begin
              if (val_x < SB_X && val_x <= wp_x) begin
                rs_next = val_x[AW-1:0];
              end else begin
                ok_next = 1'b0;
              end
            end
            REQ_READ: begin
              if (val_x < SB_X) begin
                mem_raddr  = val_x[AW-1:0];
                state_next = ST_READ;
              end
            end
            REQ_WRITE: begin
              if (val_x < SB_X) begin
                mem_we    = 1'b1;
                mem_waddr = val_x[AW-1:0];
                mem_wdata = req.data_byte;
              end else begin
                ok_next = 1'b0;
              end
            end
            REQ_CLEAR: begin
              wp_next = '0;
              rp_next = '0;
              rs_next = '0;
              lc_next = '0;
              pl_next = '0;
            end
            default: begin
              ok_next = 1'b0;
            end
          endcase
        end
      end

      ST_STEP: begin
        if (fwd) begin
          if (rp < rs || rp >= wp) begin
            step_fail = 1'b1;
          end else begin
            scan_addr_next = rp;
            scan_on_next   = 1'b1;
            chk_v_next     = 1'b0;
            state_next     = ST_NSCAN;
          end
        end else begin
          if (lc == '0 || rp <= rs) begin
            step_fail = 1'b1;
          end else if ((rp - 1'b1) < wp && (rp - 1'b1) > rs) begin
            mem_raddr  = rp - 1'b1;
            state_next = ST_PCHK;
          end else if ((rp - 1'b1) == rs) begin
            rp_next = rs;
            lc_next = lc - 1'b1;
            step_ok = 1'b1;
          end else begin
            step_fail = 1'b1;
          end
        end
      end

      ST_NSCAN: begin
        mem_raddr      = scan_addr;
        scan_addr_next = scan_addr + 1'b1;
        scan_on_next   = scan_on && ((AW+1)'(scan_addr) + 1'b1 < (AW+1)'(wp));
        chk_v_next     = scan_on;
        chk_addr_next  = scan_addr;
        if (chk_v) begin
          if (mem_rdata == 8'd0) begin
            rp_next = chk_addr + 1'b1;
            lc_next = lc + 1'b1;
            step_ok = 1'b1;
          end else if ((AW+1)'(chk_addr) + 1'b1 >= (AW+1)'(wp)) begin
            step_fail = 1'b1;
          end
        end
      end

      ST_PCHK: begin
        if (mem_rdata == 8'd0) begin
          scan_addr_next = rp - 2'd2;
          scan_on_next   = 1'b1;
          chk_v_next     = 1'b0;
          state_next     = ST_PSCAN;
        end else begin
          step_fail = 1'b1;
        end
      end

      ST_PSCAN: begin
        mem_raddr      = scan_addr;
        scan_addr_next = scan_addr - 1'b1;
        scan_on_next   = scan_on && (scan_addr != rs);
        chk_v_next     = scan_on;
        chk_addr_next  = scan_addr;
        if (chk_v) begin
          if (mem_rdata == 8'd0) begin
            rp_next = chk_addr + 1'b1;
            lc_next = lc - 1'b1;
            step_ok = 1'b1;
          end else if (chk_addr == rs) begin
            rp_next = rs;
            lc_next = lc - 1'b1;
            step_ok = 1'b1;
          end
        end
      end

      ST_END: begin
        if (mem_rdata == 8'd0 && (wp - 1'b1) >= rs) begin
          rp_next = wp;
        end else begin
          ok_next = 1'b0;
        end
        state_next = ST_FIN;
      end

      ST_READ: begin
        rdata_next = mem_rdata;
        state_next = ST_FIN;
      end

      ST_FIN: begin
        if (res_ready) begin
          state_next  = ST_IDLE;
          is_try_next = 1'b0;
          if (is_try) begin
            rp_next = save_rp;
            lc_next = save_lc;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // common tail of one next/prev step
    if (step_ok) begin
      if (multi && (fwd ? (lc_next < target) : (lc_next != '0 && lc_next > target))) begin
        state_next = ST_STEP;
      end else begin
        state_next = ST_FIN;
      end
    end
    if (step_fail) begin
      ok_next    = 1'b0;
      state_next = ST_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wp      <= '0;
      rp      <= '0;
      rs      <= '0;
      lc      <= '0;
      pl      <= '0;
      is_try  <= 1'b0;
      scan_on <= 1'b0;
      chk_v   <= 1'b0;
    end else begin
      state   <= state_next;
      wp      <= wp_next;
      rp      <= rp_next;
      rs      <= rs_next;
      lc      <= lc_next;
      pl      <= pl_next;
      is_try  <= is_try_next;
      scan_on <= scan_on_next;
      chk_v   <= chk_v_next;
    end
  end

  always_ff @(posedge clk) begin
    target    <= target_next;
    fwd       <= fwd_next;
    multi     <= multi_next;
    save_rp   <= save_rp_next;
    save_lc   <= save_lc_next;
    scan_addr <= scan_addr_next;
    chk_addr  <= chk_addr_next;
    ok        <= ok_next;
    rdata     <= rdata_next;
  end

  // after a trial walk the remaining count is taken from the saved read pointer
  assign shown_rp = is_try ? save_rp : rp;

  always_comb begin
    res.status      = ~ok;
    res.read_pos    = FIELD_W'(rp);
    res.line_number = is_try ? save_lc : lc;
    res.write_pos   = FIELD_W'(wp);
    res.begin_pos   = FIELD_W'(rs);
    res.read_data   = rdata;
    res.remaining   = (wp >= shown_rp) ? FIELD_W'(wp - shown_rp) : '0;
  end

  a_rp_le_wp: assert property (@(posedge clk) disable iff (rst) rp <= wp)
    else $error("read pointer past write pointer");
  a_rs_le_wp: assert property (@(posedge clk) disable iff (rst) rs <= wp)
    else $error("region start past write pointer");
  a_pl_sat: assert property (@(posedge clk) disable iff (rst) pl <= SB_P)
    else $error("pending length over limit");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
      (state == ST_FIN && res_ready) |=> state == ST_IDLE)
    else $error("result handoff did not return to idle");
  a_no_write_scan: assert property (@(posedge clk) disable iff (rst)
      (state == ST_NSCAN || state == ST_PSCAN) |-> !mem_we)
    else $error("store written during a scan");

endmodule

// ===== hw/rtl/string_record_buffer_navigator_top.sv =====
// Top level of the text line buffer navigator: store, sequencer and result register.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+------------------------------------
//  req     | in  | req_valid/req_stall| req_type, data_byte, value
//  rsp     | out | rsp_valid/rsp_stall| status, positions, counter, byte
//
// Simple requests (append, pointer moves, raw write, clear) go from idle
// straight to the result state; raw read and goto end first wait on a store
// read. Next/prev scan the store one byte per cycle through its single read
// port; goto/try repeat the next/prev step for every further line walked.
// The result register lets a new word be taken while the previous result
// waits on rsp_stall. Reset clears pointers, counter and pending length;
// the store contents are not cleared.
module string_record_buffer_navigator_top #(
  parameter int STORE_BYTES = srbn_pkg::STORE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  srbn_pkg::in_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output srbn_pkg::out_t rsp
);
  import srbn_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  logic          res_valid, res_ready;
  out_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  srbn_mem #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  srbn_ctrl #(
    .STORE_BYTES (STORE_BYTES),
    .AW          (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule

// ===== bench/tb_string_record_buffer_navigator_top.sv =====
// Self-checking bench for the text line buffer navigator: table, random requests, scoreboard.
module tb_string_record_buffer_navigator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import srbn_pkg::*;

  localparam int          STORE      = STORE_BYTES_DEF;
  localparam int unsigned PTR_MASK   = 32'h3FFF;
  localparam logic [3:0]  UNUSED_REQ = 4'hF;   // codes 13..15 are not decoded
  localparam int          RAND_WORDS = 1330;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_t  req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_t rsp;

  string_record_buffer_navigator_top DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the handshake locks up (3 s of simulated time).
  initial begin
    repeat (3000) #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Line buffer predictor. known[] marks bytes that have been written at least
  // once; a candidate word whose prediction touches an unknown byte is dropped.
  // ---------------------------------------------------------------------------
  bit [7:0]    text_mem [STORE];
  bit          known    [STORE];
  int unsigned wr_ptr, rd_ptr, rg_start, line_cnt, pend_len;
  bit          blank_hit;
  int          lines_committed, words_sent, results_seen, mismatches;
  int          line_left;          // bytes still to go in the line being generated

  out_t        line_results [$];   // expected results, oldest first

  function automatic bit [7:0] peek(int unsigned a);
    if (!known[a]) blank_hit = 1'b1;
    return text_mem[a];
  endfunction

  // one line forward: needs a terminator before the write pointer
  function automatic bit walk_fwd(inout int unsigned rd, inout int unsigned ln,
                                  input int unsigned wr, input int unsigned rg);
    if (rd < rg || rd >= wr) return 1'b0;
    for (int unsigned j = rd; j < wr; j++)
      if (peek(j) == 8'd0) begin
        rd = j + 1;
        ln = (ln + 1) & PTR_MASK;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  // one line back: byte before rd must be a terminator, or rd sits just past begin
  function automatic bit walk_back(inout int unsigned rd, inout int unsigned ln,
                                   input int unsigned wr, input int unsigned rg);
    int unsigned a, j, s;
    if (ln == 0 || rd <= rg) return 1'b0;
    a = rd - 1;
    if (a < wr && a > rg && peek(a) == 8'd0) begin
      j = a - 1;
      while (1) begin
        if (peek(j) == 8'd0) begin
          s = j + 1;
          break;
        end
        if (j == rg) begin
          s = rg;
          break;
        end
        j--;
      end
    end else if (a == rg) begin
      s = rg;
    end else begin
      return 1'b0;
    end
    rd = s;
    ln = (ln - 1) & PTR_MASK;
    return 1'b1;
  endfunction

  function automatic bit walk_to(input int unsigned tgt, inout int unsigned rd,
                                 inout int unsigned ln, input int unsigned wr,
                                 input int unsigned rg);
    bit ok;
    ok = 1'b1;
    if (ln < tgt) begin
      do ok = walk_fwd(rd, ln, wr, rg); while (ln < tgt && ok);
    end else if (ln > tgt) begin
      do ok = walk_back(rd, ln, wr, rg); while (ln > 0 && ln > tgt && ok);
    end
    return ok;
  endfunction

  // Predicts the result of one word; state and store change only when apply is set.
  function automatic out_t predict_line_op(in_t w, bit apply);
    int unsigned wr, rd, rg, ln, pl, v, addr, shown;
    bit          ok, has_shown;
    bit [7:0]    b, rdata;
    out_t        r;
    wr = wr_ptr; rd = rd_ptr; rg = rg_start; ln = line_cnt; pl = pend_len;
    v = {18'd0, w.value}; b = w.data_byte;
    ok = 1'b1; has_shown = 1'b0; rdata = 8'd0; shown = 0;
    case (req_code_t'(w.req_type))
      REQ_APPEND: begin
        if (b != 8'd0) begin
          addr = wr + pl;
          if (addr < STORE - 1 && apply) begin
            text_mem[addr] = b;
            known[addr]    = 1'b1;
          end
          if (pl < STORE) pl++;
        end else begin
          if (wr + pl + 1 < STORE) begin
            if (apply) begin
              text_mem[wr + pl] = 8'd0;
              known[wr + pl]    = 1'b1;
              lines_committed++;
            end
            wr = wr + pl + 1;
          end else begin
            ok = 1'b0;
          end
          pl = 0;
        end
      end
      REQ_NEXT: ok = walk_fwd(rd, ln, wr, rg);
      REQ_PREV: ok = walk_back(rd, ln, wr, rg);
      REQ_GOTO: ok = walk_to(v, rd, ln, wr, rg);
      REQ_TRY: begin
        int unsigned rd_t, ln_t;
        rd_t = rd; ln_t = ln;
        ok = walk_to(v, rd_t, ln_t, wr, rg);
        shown = rd_t;
        has_shown = 1'b1;
      end
      REQ_BEGIN: begin
        ln = 0;
        if (rg <= wr) rd = rg; else ok = 1'b0;
      end
      REQ_END: begin
        ln = 0;
        if (wr != 0 && peek(wr - 1) == 8'd0 && wr - 1 >= rg) rd = wr;
        else ok = 1'b0;
      end
      REQ_GOTO_POS:  if (v >= rg && v <= wr) rd = v; else ok = 1'b0;
      REQ_SET_WRITE: begin
        if (v < STORE && v >= rg && v >= rd) begin
          wr = v;
          pl = 0;
        end else begin
          ok = 1'b0;
        end
      end
      REQ_SET_BEGIN: if (v < STORE && v <= wr) rg = v; else ok = 1'b0;
      REQ_READ:      if (v < STORE) rdata = peek(v);
      REQ_WRITE: begin
        if (v < STORE) begin
          if (apply) begin
            text_mem[v] = b;
            known[v]    = 1'b1;
          end
        end else begin
          ok = 1'b0;
        end
      end
      REQ_CLEAR: begin
        wr = 0; rd = 0; rg = 0; ln = 0; pl = 0;
      end
      default: ok = 1'b0;
    endcase
    if (!has_shown) shown = rd;
    r.status      = !ok;
    r.read_pos    = shown[FIELD_W-1:0];
    r.line_number = ln[FIELD_W-1:0];
    r.write_pos   = wr[FIELD_W-1:0];
    r.begin_pos   = rg[FIELD_W-1:0];
    r.read_data   = rdata;
    r.remaining   = (wr >= rd) ? FIELD_W'(wr - rd) : '0;
    if (apply) begin
      wr_ptr = wr; rd_ptr = rd; rg_start = rg; line_cnt = ln; pend_len = pl;
    end
    return r;
  endfunction

  function automatic in_t mk_word(req_code_t op, logic [7:0] b, int unsigned v);
    in_t w;
    w.req_type  = op;
    w.data_byte = b;
    w.value     = v[FIELD_W-1:0];
    return w;
  endfunction

  function automatic int unsigned near(int unsigned base, int lo, int hi);
    int t;
    t = int'(base) + $urandom_range(hi - lo) + lo;
    if (t < 0) t = 0;
    return t & PTR_MASK;
  endfunction

  // Random word: mostly whole lines and sensible moves, some noise.
  function automatic in_t random_word();
    int unsigned k;
    logic [7:0]  b;
    b = 8'($urandom_range(255, 1));
    if (line_left > 0 && $urandom_range(99) < 90) begin
      line_left--;
      return mk_word(REQ_APPEND, b, $urandom);
    end
    if (line_left == 0 && pend_len > 0 && $urandom_range(99) < 90)
      return mk_word(REQ_APPEND, 8'd0, $urandom);
    if (wr_ptr > 2500)   // keep lines short to walk
      return mk_word(REQ_CLEAR, 8'($urandom), $urandom);
    k = $urandom_range(99);
    if (k < 25) begin
      line_left = ($urandom_range(19) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
      if (line_left == 0) return mk_word(REQ_APPEND, 8'd0, $urandom);
      line_left--;
      return mk_word(REQ_APPEND, b, $urandom);
    end
    if (k < 40) return mk_word(REQ_NEXT, 8'($urandom), $urandom);
    if (k < 52) return mk_word(REQ_PREV, 8'($urandom), $urandom);
    if (k < 66)
      return mk_word((k < 60) ? REQ_GOTO : REQ_TRY, 8'($urandom),
                     ($urandom_range(19) == 0) ? $urandom : near(line_cnt, -4, 6));
    if (k < 70) return mk_word(REQ_BEGIN, 8'($urandom), $urandom);
    if (k < 74) return mk_word(REQ_END, 8'($urandom), $urandom);
    if (k < 79)
      return mk_word(REQ_GOTO_POS, 8'($urandom),
                     ($urandom_range(9) == 0) ? $urandom : near(rd_ptr, -20, 20));
    if (k < 83)
      return mk_word(REQ_SET_WRITE, 8'($urandom),
                     ($urandom_range(9) == 0) ? $urandom : near(wr_ptr, -10, 4));
    if (k < 86)
      return mk_word(REQ_SET_BEGIN, 8'($urandom),
                     ($urandom_range(9) == 0) ? $urandom : near(rg_start, -4, 20));
    if (k < 91)
      return mk_word(REQ_READ, 8'($urandom),
                     ($urandom_range(9) == 0) ? $urandom : $urandom_range(wr_ptr + 2));
    if (k < 95)
      return mk_word(REQ_WRITE, ($urandom_range(3) == 0) ? 8'd0 : b,
                     ($urandom_range(9) == 0) ? $urandom : $urandom_range(wr_ptr + 2));
    if (k < 97) return mk_word(REQ_CLEAR, 8'($urandom), $urandom);
    if (k < 99) begin
      in_t w;
      w = mk_word(REQ_APPEND, 8'($urandom), $urandom);
      w.req_type = 4'($urandom_range(15, 13));
      return w;
    end
    return mk_word(REQ_APPEND, 8'd0, $urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stall, plus long hold-offs requested by the stimulus.
  // ---------------------------------------------------------------------------
  int stall_pct, idle_pct;
  int hold_asks, hold_done, hold_left;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (hold_asks != hold_done) begin
      hold_done++;
      hold_left = 400;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic flag_mismatch(string what, int got, int want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // Scoreboard: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      out_t want;
      results_seen++;
      if (line_results.size() == 0) begin
        flag_mismatch("unexpected word", int'(rsp.read_pos), 0);
      end else begin
        want = line_results.pop_front();
        if (rsp.status !== want.status)
          flag_mismatch("status", int'(rsp.status), int'(want.status));
        if (rsp.read_pos !== want.read_pos)
          flag_mismatch("read_pos", int'(rsp.read_pos), int'(want.read_pos));
        if (rsp.line_number !== want.line_number)
          flag_mismatch("line_number", int'(rsp.line_number), int'(want.line_number));
        if (rsp.write_pos !== want.write_pos)
          flag_mismatch("write_pos", int'(rsp.write_pos), int'(want.write_pos));
        if (rsp.begin_pos !== want.begin_pos)
          flag_mismatch("begin_pos", int'(rsp.begin_pos), int'(want.begin_pos));
        if (rsp.read_data !== want.read_data)
          flag_mismatch("read_data", int'(rsp.read_data), int'(want.read_data));
        if (rsp.remaining !== want.remaining)
          flag_mismatch("remaining", int'(rsp.remaining), int'(want.remaining));
      end
    end
  end

  // Offer one word, hold it until taken, then record what it should produce.
  task automatic send_word(in_t w, out_t want);
    int n;
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    line_results.push_back(want);
    words_sent++;
    if ($urandom_range(99) < idle_pct) begin
      n = $urandom_range(4, 1);
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: typed results only where they are obvious.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_t  w;
    bit   typed;
    out_t want;
  } table_row_t;

  table_row_t dir_rows [$];

  function automatic out_t mk_result(bit st, int rd, int ln, int wr, int bg, int d, int rem);
    out_t r;
    r.status = st; r.read_pos = FIELD_W'(rd); r.line_number = FIELD_W'(ln);
    r.write_pos = FIELD_W'(wr); r.begin_pos = FIELD_W'(bg); r.read_data = 8'(d);
    r.remaining = FIELD_W'(rem);
    return r;
  endfunction

  function automatic void add_row(in_t w, bit typed = 1'b0, out_t want = '0);
    table_row_t t;
    t.w = w; t.typed = typed; t.want = want;
    dir_rows.push_back(t);
  endfunction

  initial begin
    in_t  w;
    out_t want;
    int   phase;

    // empty buffer right after reset: moves fail, nothing changes
    add_row(mk_word(REQ_NEXT, 8'h00, 0), 1'b1, mk_result(1, 0, 0, 0, 0, 0, 0));
    add_row(mk_word(REQ_PREV, 8'hFF, 16383), 1'b1, mk_result(1, 0, 0, 0, 0, 0, 0));
    add_row(mk_word(REQ_END, 8'h00, 0), 1'b1, mk_result(1, 0, 0, 0, 0, 0, 0));
    w = mk_word(REQ_APPEND, 8'hFF, 16383);
    w.req_type = UNUSED_REQ;
    add_row(w, 1'b1, mk_result(1, 0, 0, 0, 0, 0, 0));
    // top byte of the store, raw access
    add_row(mk_word(REQ_WRITE, 8'hA5, 16383), 1'b1, mk_result(0, 0, 0, 0, 0, 0, 0));
    add_row(mk_word(REQ_READ, 8'h00, 16383), 1'b1, mk_result(0, 0, 0, 0, 0, 8'hA5, 0));
    // two lines, then walk them
    add_row(mk_word(REQ_APPEND, 8'h41, 0));
    add_row(mk_word(REQ_APPEND, 8'h42, 0));
    add_row(mk_word(REQ_APPEND, 8'h00, 0));
    add_row(mk_word(REQ_APPEND, 8'hFF, 0));
    add_row(mk_word(REQ_APPEND, 8'h00, 0));
    add_row(mk_word(REQ_NEXT, 8'h00, 0));
    add_row(mk_word(REQ_NEXT, 8'h00, 0));
    add_row(mk_word(REQ_PREV, 8'h00, 0));
    add_row(mk_word(REQ_GOTO, 8'h00, 16383));
    add_row(mk_word(REQ_TRY, 8'h00, 0));
    add_row(mk_word(REQ_BEGIN, 8'h00, 0));
    add_row(mk_word(REQ_END, 8'h00, 0));
    add_row(mk_word(REQ_GOTO_POS, 8'h00, 2));
    add_row(mk_word(REQ_SET_BEGIN, 8'h00, 3));
    // line that cannot fit at the top of the store
    add_row(mk_word(REQ_SET_WRITE, 8'h00, 16382));
    add_row(mk_word(REQ_APPEND, 8'h7F, 0));
    add_row(mk_word(REQ_APPEND, 8'h00, 0));
    add_row(mk_word(REQ_CLEAR, 8'h00, 0));
    add_row(mk_word(REQ_GOTO_POS, 8'h00, 16383));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      want = predict_line_op(dir_rows[i].w, 1'b1);
      send_word(dir_rows[i].w, dir_rows[i].typed ? dir_rows[i].want : want);
    end

    // Random part in five phases: clean, sender gaps, receiver stalls,
    // both, and clean again with a long receiver hold-off up front.
    for (int i = 0; i < RAND_WORDS; i++) begin
      phase = i * 5 / RAND_WORDS;
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 60; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 60; end
        3:       begin idle_pct = 18; stall_pct = 18; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      if (i == RAND_WORDS * 4 / 5) hold_asks++;
      do begin
        w = random_word();
        blank_hit = 1'b0;
        want = predict_line_op(w, 1'b0);
      end while (blank_hit);
      want = predict_line_op(w, 1'b1);
      send_word(w, want);
    end
    req_valid <= 1'b0;
    stall_pct = 0;

    while (line_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("ran %0d requests (%0d from the table), %0d results checked", words_sent,
             dir_rows.size(), results_seen);
    $display("%0d lines committed across all five traffic phases", lines_committed);
    if (mismatches == 0 && line_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
